/* sv/wal_pkg.sv */
`default_nettype none

package wal_pkg;

  localparam int MaxEntries = 29;
  localparam int AddrW      = $clog2(MaxEntries);
  localparam int CountW     = 5;
  localparam int BlockW     = 32;
  localparam int SizeW      = 5;

  typedef enum logic [2:0] {
    ACT_BEGIN   = 3'd0,
    ACT_WRITE   = 3'd1,
    ACT_COMMIT  = 3'd2,
    ACT_RESTORE = 3'd3,
    ACT_RECOVER = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    KIND_COPY   = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NESTED_BEGIN = 3'd1,
    ST_END_NO_BEGIN = 3'd2,
    ST_WRITE_OUTSIDE = 3'd3,
    ST_LOG_FULL     = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    CFG_LOG_START = 1'b0,
    CFG_LOG_SIZE  = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    E_STATUS,
    E_RESTORE,
    E_WCOPY,
    E_TOLOG,
    E_HOME,
    E_HDR_N,
    E_HDR_ZERO
  } emit_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_W_COPY,
    S_W_FULL,
    S_C_RD1,
    S_C_EM1,
    S_C_HDR,
    S_C_RD2,
    S_C_EM2,
    S_C_HDR0,
    S_R_RD,
    S_R_EM,
    S_R_HDR
  } state_t;

  typedef struct packed {
    action_t           action;
    logic [BlockW-1:0] block_number;
  } wal_in_t;

  typedef struct packed {
    kind_t             kind;
    logic [BlockW-1:0] copy_source;
    logic [BlockW-1:0] copy_target;
    logic [CountW-1:0] header_count;
    logic [CountW-1:0] slot;
    status_t           status;
    logic              last;
  } wal_out_t;

  typedef struct packed {
    logic     ld_in;
    logic     rd_en;
    logic     wr_en;
    logic     idx_clr;
    logic     idx_inc;
    logic     wslot_ld_hit;
    logic     wslot_ld_n;
    logic     set_tx;
    logic     clr_tx;
    logic     clr_n;
    logic     emit;
    emit_op_t op;
    status_t  code;
    logic     last;
  } wal_cmd_t;

  typedef struct packed {
    action_t act;
    logic    in_tx;
    logic    slot_free;
    logic    n_zero;
    logic    full;
    logic    idx_eq_n;
    logic    idx_last;
    logic    hit;
  } wal_sts_t;

endpackage

`default_nettype wire

/* sv/wal_ram.sv */
`default_nettype none

module wal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 29
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/wal_ctrl.sv */
`default_nettype none

module wal_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire wal_pkg::wal_sts_t sts,
  output      wal_pkg::wal_cmd_t cmd
);

  wal_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wal_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.op     = wal_pkg::E_STATUS;
    cmd.code   = wal_pkg::ST_OK;
    unique case (state)
      wal_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_in  = 1'b1;
          state_next = wal_pkg::S_DISPATCH;
        end
      end
      wal_pkg::S_DISPATCH: begin
        unique case (sts.act)
          wal_pkg::ACT_BEGIN: begin
            if (sts.slot_free) begin
              cmd.emit   = 1'b1;
              cmd.last   = 1'b1;
              cmd.code   = sts.in_tx ? wal_pkg::ST_NESTED_BEGIN : wal_pkg::ST_OK;
              cmd.set_tx = !sts.in_tx;
              state_next = wal_pkg::S_IDLE;
            end
          end
          wal_pkg::ACT_WRITE: begin
            if (!sts.in_tx) begin
              if (sts.slot_free) begin
                cmd.emit   = 1'b1;
                cmd.last   = 1'b1;
                cmd.code   = wal_pkg::ST_WRITE_OUTSIDE;
                state_next = wal_pkg::S_IDLE;
              end
            end else begin
              state_next = wal_pkg::S_SEARCH;
            end
          end
          wal_pkg::ACT_COMMIT: begin
            if (!sts.in_tx) begin
              if (sts.slot_free) begin
                cmd.emit   = 1'b1;
                cmd.last   = 1'b1;
                cmd.code   = wal_pkg::ST_END_NO_BEGIN;
                state_next = wal_pkg::S_IDLE;
              end
            end else if (sts.n_zero) begin
              if (sts.slot_free) begin
                cmd.emit   = 1'b1;
                cmd.last   = 1'b1;
                cmd.clr_n  = 1'b1;
                cmd.clr_tx = 1'b1;
                state_next = wal_pkg::S_IDLE;
              end
            end else begin
              state_next = wal_pkg::S_C_RD1;
            end
          end
          wal_pkg::ACT_RESTORE: begin
            if (sts.slot_free) begin
              cmd.emit = 1'b1;
              cmd.last = 1'b1;
              if (sts.full) begin
                cmd.code = wal_pkg::ST_LOG_FULL;
              end else begin
                cmd.op    = wal_pkg::E_RESTORE;
                cmd.wr_en = 1'b1;
              end
              state_next = wal_pkg::S_IDLE;
            end
          end
          wal_pkg::ACT_RECOVER: begin
            if (sts.n_zero) begin
              if (sts.slot_free) begin
                cmd.emit   = 1'b1;
                cmd.last   = 1'b1;
                cmd.op     = wal_pkg::E_HDR_ZERO;
                cmd.clr_n  = 1'b1;
                state_next = wal_pkg::S_IDLE;
              end
            end else begin
              state_next = wal_pkg::S_R_RD;
            end
          end
          default: begin
            if (sts.slot_free) begin
              cmd.emit   = 1'b1;
              cmd.last   = 1'b1;
              state_next = wal_pkg::S_IDLE;
            end
          end
        endcase
      end
      wal_pkg::S_SEARCH: begin
        if (sts.hit) begin
          cmd.wslot_ld_hit = 1'b1;
          state_next       = wal_pkg::S_W_COPY;
        end else if (sts.idx_eq_n) begin
          if (sts.full) begin
            state_next = wal_pkg::S_W_FULL;
          end else begin
            cmd.wr_en      = 1'b1;
            cmd.wslot_ld_n = 1'b1;
            state_next     = wal_pkg::S_W_COPY;
          end
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.idx_inc = 1'b1;
        end
      end
      wal_pkg::S_W_COPY: begin
        if (sts.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.last   = 1'b1;
          cmd.op     = wal_pkg::E_WCOPY;
          state_next = wal_pkg::S_IDLE;
        end
      end
      wal_pkg::S_W_FULL: begin
        if (sts.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.last   = 1'b1;
          cmd.code   = wal_pkg::ST_LOG_FULL;
          state_next = wal_pkg::S_IDLE;
        end
      end
      wal_pkg::S_C_RD1: begin
        cmd.rd_en  = 1'b1;
        state_next = wal_pkg::S_C_EM1;
      end
      wal_pkg::S_C_EM1: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          cmd.op   = wal_pkg::E_TOLOG;
          if (sts.idx_last) begin
            cmd.idx_clr = 1'b1;
            state_next  = wal_pkg::S_C_HDR;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = wal_pkg::S_C_RD1;
          end
        end
      end
      wal_pkg::S_C_HDR: begin
        if (sts.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.op     = wal_pkg::E_HDR_N;
          state_next = wal_pkg::S_C_RD2;
        end
      end
      wal_pkg::S_C_RD2: begin
        cmd.rd_en  = 1'b1;
        state_next = wal_pkg::S_C_EM2;
      end
      wal_pkg::S_C_EM2: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          cmd.op   = wal_pkg::E_HOME;
          if (sts.idx_last) begin
            state_next = wal_pkg::S_C_HDR0;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = wal_pkg::S_C_RD2;
          end
        end
      end
      wal_pkg::S_C_HDR0: begin
        if (sts.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.last   = 1'b1;
          cmd.op     = wal_pkg::E_HDR_ZERO;
          cmd.clr_n  = 1'b1;
          cmd.clr_tx = 1'b1;
          state_next = wal_pkg::S_IDLE;
        end
      end
      wal_pkg::S_R_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = wal_pkg::S_R_EM;
      end
      wal_pkg::S_R_EM: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          cmd.op   = wal_pkg::E_HOME;
          if (sts.idx_last) begin
            state_next = wal_pkg::S_R_HDR;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = wal_pkg::S_R_RD;
          end
        end
      end
      wal_pkg::S_R_HDR: begin
        if (sts.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.last   = 1'b1;
          cmd.op     = wal_pkg::E_HDR_ZERO;
          cmd.clr_n  = 1'b1;
          state_next = wal_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = wal_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/wal_dp.sv */
`default_nettype none

module wal_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire wal_pkg::wal_in_t              in_item,
  input  wire logic                          cfg_we,
  input  wire logic [0:0]                    cfg_index,
  input  wire logic [wal_pkg::BlockW-1:0]    cfg_data,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      wal_pkg::wal_out_t             out_item,
  input  wire wal_pkg::wal_cmd_t             cmd,
  output      wal_pkg::wal_sts_t             sts
);

  logic [wal_pkg::BlockW-1:0] log_start;
  logic [wal_pkg::SizeW-1:0]  log_size;
  wal_pkg::action_t           act;
  logic [wal_pkg::BlockW-1:0] blk;
  logic [wal_pkg::CountW-1:0] count;
  logic                       in_tx;
  logic [wal_pkg::AddrW-1:0]  idx;
  logic [wal_pkg::AddrW-1:0]  ridx;
  logic                       rvalid;
  logic [wal_pkg::AddrW-1:0]  wslot;
  logic [wal_pkg::BlockW-1:0] rdata;
  logic [wal_pkg::SizeW-1:0]  cap;
  logic [wal_pkg::AddrW-1:0]  base;
  logic [wal_pkg::BlockW-1:0] log_blk;
  wal_pkg::wal_out_t          res;
  logic                       slot_free;

  wal_ram #(
    .WIDTH(wal_pkg::BlockW),
    .DEPTH(wal_pkg::MaxEntries)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.wr_en),
    .waddr(count[wal_pkg::AddrW-1:0]),
    .wdata(blk),
    .re   (cmd.rd_en),
    .raddr(idx),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      log_start <= '0;
      log_size  <= wal_pkg::SizeW'(30);
    end else if (cfg_we) begin
      unique case (wal_pkg::cfg_index_t'(cfg_index))
        wal_pkg::CFG_LOG_START: log_start <= cfg_data;
        wal_pkg::CFG_LOG_SIZE:  log_size  <= cfg_data[wal_pkg::SizeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      in_tx     <= 1'b0;
      rvalid    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rvalid <= cmd.rd_en;
      if (cmd.set_tx) begin
        in_tx <= 1'b1;
      end else if (cmd.clr_tx) begin
        in_tx <= 1'b0;
      end
      if (cmd.clr_n) begin
        count <= '0;
      end else if (cmd.wr_en) begin
        count <= count + wal_pkg::CountW'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      act <= in_item.action;
      blk <= in_item.block_number;
    end
    if (cmd.ld_in || cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + wal_pkg::AddrW'(1);
    end
    if (cmd.rd_en) begin
      ridx <= idx;
    end
    if (cmd.wslot_ld_hit) begin
      wslot <= ridx;
    end else if (cmd.wslot_ld_n) begin
      wslot <= count[wal_pkg::AddrW-1:0];
    end
    if (cmd.emit) begin
      out_item <= res;
    end
  end

  always_comb begin
    if (log_size == '0) begin
      cap = '0;
    end else if (log_size - wal_pkg::SizeW'(1) > wal_pkg::SizeW'(wal_pkg::MaxEntries)) begin
      cap = wal_pkg::SizeW'(wal_pkg::MaxEntries);
    end else begin
      cap = log_size - wal_pkg::SizeW'(1);
    end
  end

  assign slot_free = !out_valid || out_ready;
  assign base      = (cmd.op == wal_pkg::E_WCOPY) ? wslot : idx;
  assign log_blk   = log_start + wal_pkg::BlockW'(base) + wal_pkg::BlockW'(1);

  always_comb begin
    res              = '0;
    res.kind         = wal_pkg::KIND_STATUS;
    res.status       = cmd.code;
    res.last         = cmd.last;
    unique case (cmd.op)
      wal_pkg::E_STATUS: ;
      wal_pkg::E_RESTORE: begin
        res.status = wal_pkg::ST_OK;
        res.slot   = count;
      end
      wal_pkg::E_WCOPY: begin
        res.kind        = wal_pkg::KIND_COPY;
        res.status      = wal_pkg::ST_OK;
        res.copy_source = blk;
        res.copy_target = log_blk;
        res.slot        = wal_pkg::CountW'(wslot);
      end
      wal_pkg::E_TOLOG: begin
        res.kind        = wal_pkg::KIND_COPY;
        res.status      = wal_pkg::ST_OK;
        res.copy_source = rdata;
        res.copy_target = log_blk;
      end
      wal_pkg::E_HOME: begin
        res.kind        = wal_pkg::KIND_COPY;
        res.status      = wal_pkg::ST_OK;
        res.copy_source = log_blk;
        res.copy_target = rdata;
      end
      wal_pkg::E_HDR_N: begin
        res.kind         = wal_pkg::KIND_HEADER;
        res.status       = wal_pkg::ST_OK;
        res.header_count = count;
      end
      wal_pkg::E_HDR_ZERO: begin
        res.kind   = wal_pkg::KIND_HEADER;
        res.status = wal_pkg::ST_OK;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts           = '0;
    sts.act       = act;
    sts.in_tx     = in_tx;
    sts.slot_free = slot_free;
    sts.n_zero    = (count == '0);
    sts.full      = (count >= cap);
    sts.idx_eq_n  = (wal_pkg::CountW'(idx) == count);
    sts.idx_last  = (wal_pkg::CountW'(idx) + wal_pkg::CountW'(1) == count);
    sts.hit       = rvalid && (rdata == blk);
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= wal_pkg::CountW'(wal_pkg::MaxEntries))
    else $error("entry count beyond table depth");

  a_wr_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> (count < cap))
    else $error("table append while full");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> slot_free)
    else $error("result loaded over an untaken result");

  a_rd_written: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> (wal_pkg::CountW'(idx) < count))
    else $error("read of an unwritten table entry");

endmodule

`default_nettype wire

/* sv/write_ahead_log_controller.sv */
// Channel   Handshake              Payload
// in        in_valid / in_ready    in_item   (wal_pkg::wal_in_t)
// out       out_valid / out_ready  out_item  (wal_pkg::wal_out_t)
// cfg       cfg_we                 cfg_index, cfg_data
//
// One transaction at a time; in_ready is high only while the sequencer is idle.
// Begin, restore and unknown actions answer straight from dispatch. Write runs a
// table search over n logged entries (one entry-table port read per cycle).
// Commit and recover emit each copy through a read state and then an emit state.
// A single output register decouples the sides; out_ready low stalls emission.
// Synchronous reset clears the entry count and transaction flag and resets the config.
`default_nettype none

module write_ahead_log_controller (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output      logic                       in_ready,
  input  wire wal_pkg::wal_in_t           in_item,
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      wal_pkg::wal_out_t          out_item,
  input  wire logic                       cfg_we,
  input  wire logic [0:0]                 cfg_index,
  input  wire logic [wal_pkg::BlockW-1:0] cfg_data
);

  wal_pkg::wal_cmd_t cmd;
  wal_pkg::wal_sts_t sts;

  wal_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  wal_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

`default_nettype wire

/* tb/sv/wal_journal_checker.sv */
`default_nettype none

module wal_journal_checker
  import wal_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire wal_in_t           in_item,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire wal_out_t          out_item,
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [BlockW-1:0] cfg_data,
  output int                     fails,
  output int                     pending
);

  logic [BlockW-1:0] log_start;
  logic [SizeW-1:0]  log_size;
  logic [BlockW-1:0] journal [MaxEntries];
  int unsigned       entry_count;
  logic              in_tx;
  wal_out_t          due_q[$];
  int                mismatches = 0;

  assign fails = mismatches;

  initial pending = 0;

  function automatic int unsigned log_capacity();
    int unsigned lim;
    lim = (log_size >= 1) ? log_size - 1 : 0;
    if (lim > MaxEntries) lim = MaxEntries;
    return lim;
  endfunction

  function automatic logic [BlockW-1:0] log_addr(input int unsigned idx);
    logic [BlockW-1:0] a;
    a = log_start + BlockW'(idx) + 32'd1;
    return a;
  endfunction

  function automatic wal_out_t journal_cmd(input kind_t k, input logic [BlockW-1:0] src,
                                           input logic [BlockW-1:0] dst,
                                           input int unsigned hcount, input int unsigned sl,
                                           input status_t st);
    wal_out_t r;
    r.kind         = k;
    r.copy_source  = src;
    r.copy_target  = dst;
    r.header_count = CountW'(hcount);
    r.slot         = CountW'(sl);
    r.status       = st;
    r.last         = 1'b0;
    return r;
  endfunction

  function automatic void predict_journal(input wal_in_t it);
    wal_out_t    res[$];
    int unsigned n;
    int unsigned hit;
    n = entry_count;
    case (it.action)
      ACT_BEGIN: begin
        if (in_tx) begin
          res.push_back(journal_cmd(KIND_STATUS, '0, '0, 0, 0, ST_NESTED_BEGIN));
        end else begin
          in_tx = 1'b1;
          res.push_back(journal_cmd(KIND_STATUS, '0, '0, 0, 0, ST_OK));
        end
      end
      ACT_WRITE: begin
        if (!in_tx) begin
          res.push_back(journal_cmd(KIND_STATUS, '0, '0, 0, 0, ST_WRITE_OUTSIDE));
        end else begin
          hit = n;
          for (int unsigned i = 0; i < n; i++)
            if (hit == n && journal[i] == it.block_number) hit = i;
          if (hit == n && n >= log_capacity()) begin
            res.push_back(journal_cmd(KIND_STATUS, '0, '0, 0, 0, ST_LOG_FULL));
          end else begin
            if (hit == n) begin
              journal[n]  = it.block_number;
              entry_count = n + 1;
            end
            res.push_back(journal_cmd(KIND_COPY, it.block_number, log_addr(hit), 0, hit, ST_OK));
          end
        end
      end
      ACT_COMMIT: begin
        if (!in_tx) begin
          res.push_back(journal_cmd(KIND_STATUS, '0, '0, 0, 0, ST_END_NO_BEGIN));
        end else begin
          if (n > 0) begin
            for (int unsigned i = 0; i < n; i++)
              res.push_back(journal_cmd(KIND_COPY, journal[i], log_addr(i), 0, 0, ST_OK));
            res.push_back(journal_cmd(KIND_HEADER, '0, '0, n, 0, ST_OK));
            for (int unsigned i = 0; i < n; i++)
              res.push_back(journal_cmd(KIND_COPY, log_addr(i), journal[i], 0, 0, ST_OK));
            res.push_back(journal_cmd(KIND_HEADER, '0, '0, 0, 0, ST_OK));
          end else begin
            res.push_back(journal_cmd(KIND_STATUS, '0, '0, 0, 0, ST_OK));
          end
          entry_count = 0;
          in_tx       = 1'b0;
        end
      end
      ACT_RESTORE: begin
        if (n >= log_capacity()) begin
          res.push_back(journal_cmd(KIND_STATUS, '0, '0, 0, 0, ST_LOG_FULL));
        end else begin
          journal[n]  = it.block_number;
          entry_count = n + 1;
          res.push_back(journal_cmd(KIND_STATUS, '0, '0, 0, n, ST_OK));
        end
      end
      ACT_RECOVER: begin
        for (int unsigned i = 0; i < n; i++)
          res.push_back(journal_cmd(KIND_COPY, log_addr(i), journal[i], 0, 0, ST_OK));
        entry_count = 0;
        res.push_back(journal_cmd(KIND_HEADER, '0, '0, 0, 0, ST_OK));
      end
      default: begin
        res.push_back(journal_cmd(KIND_STATUS, '0, '0, 0, 0, ST_OK));
      end
    endcase
    foreach (res[j]) begin
      if (j == res.size() - 1) res[j].last = 1'b1;
      due_q.push_back(res[j]);
    end
  endfunction

  task automatic report(input string what, input logic [BlockW-1:0] got,
                        input logic [BlockW-1:0] want);
    if (mismatches < 200)
      $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    wal_out_t want;
    if (rst) begin
      log_start   = '0;
      log_size    = SizeW'(30);
      entry_count = 0;
      in_tx       = 1'b0;
      due_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_LOG_START) log_start = cfg_data;
        else log_size = cfg_data[SizeW-1:0];
      end
      if (in_valid && in_ready) predict_journal(in_item);
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          report("unexpected result, kind", BlockW'(out_item.kind), '0);
        end else begin
          want = due_q.pop_front();
          if (out_item.kind != want.kind)
            report("kind", BlockW'(out_item.kind), BlockW'(want.kind));
          if (out_item.copy_source != want.copy_source)
            report("copy_source", out_item.copy_source, want.copy_source);
          if (out_item.copy_target != want.copy_target)
            report("copy_target", out_item.copy_target, want.copy_target);
          if (out_item.header_count != want.header_count)
            report("header_count", BlockW'(out_item.header_count), BlockW'(want.header_count));
          if (out_item.slot != want.slot)
            report("slot", BlockW'(out_item.slot), BlockW'(want.slot));
          if (out_item.status != want.status)
            report("status", BlockW'(out_item.status), BlockW'(want.status));
          if (out_item.last != want.last)
            report("last", BlockW'(out_item.last), BlockW'(want.last));
        end
      end
    end
    pending <= due_q.size();
  end

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`default_nettype none

module testbench;
  import wal_pkg::*;

  logic              clk;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  wal_in_t           in_item   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  wal_out_t          out_item;
  logic              cfg_we    = 1'b0;
  logic [0:0]        cfg_index = '0;
  logic [BlockW-1:0] cfg_data  = '0;
  int                fails;
  int                pending;

  bit                tx_calm   = 1'b0;
  int                rx_cycle  = 0;
  logic [BlockW-1:0] recent [4] = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000};

  write_ahead_log_controller dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  wal_journal_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fails     (fails),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // stall the result side at random, except for one quiet stretch
  always @(posedge clk) begin
    rx_cycle  <= rx_cycle + 1;
    out_ready <= (rx_cycle >= 3000 && rx_cycle < 7000) || ($urandom_range(99) >= 20);
  end

  task automatic send(input action_t act, input logic [BlockW-1:0] blk);
    if (!tx_calm && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 20);
    end
    in_valid <= 1'b1;
    in_item  <= '{action: act, block_number: blk};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_log(input logic [BlockW-1:0] start, input int unsigned size);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LOG_START;
    cfg_data  <= start;
    @(posedge clk);
    cfg_index <= CFG_LOG_SIZE;
    cfg_data  <= BlockW'(size);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // reuse a recent block now and then so writes hit logged entries
  function automatic logic [BlockW-1:0] pick_block();
    logic [BlockW-1:0] v;
    if ($urandom_range(2) == 0) return recent[$urandom_range(3)];
    v = $urandom;
    recent[$urandom_range(3)] = v;
    return v;
  endfunction

  task automatic run_phase(input int quota, input int unsigned cap);
    int sent;
    int m;
    int pick;
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(99);
      m = ($urandom_range(9) == 0) ? int'(cap) + 1 + $urandom_range(1) : $urandom_range(5);
      if (pick < 70) begin
        send(ACT_BEGIN, $urandom);
        repeat (m) send(ACT_WRITE, pick_block());
        send(ACT_COMMIT, $urandom);
        sent += m + 2;
      end else if (pick < 85) begin
        repeat (m) send(ACT_RESTORE, pick_block());
        send(ACT_RECOVER, $urandom);
        sent += m + 1;
      end else begin
        send(action_t'($urandom_range(7)), pick_block());
        sent++;
      end
    end
  endtask

  initial begin
    logic [BlockW-1:0] starts [6];
    int unsigned       sizes  [6];
    int unsigned       cap;
    starts = '{32'h0, 32'hFFFF_FFFF, $urandom, 32'h8000_0000, $urandom, $urandom};
    sizes  = '{30, 2, 31, 5, 30, 1};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    set_log(32'hFFFF_FFFE, 4);

    send(ACT_WRITE, 32'h0);
    send(ACT_COMMIT, 32'h0);
    send(ACT_BEGIN, 32'h0);
    send(ACT_BEGIN, 32'hFFFF_FFFF);
    send(ACT_WRITE, 32'hFFFF_FFFF);
    send(ACT_WRITE, 32'h0);
    send(ACT_WRITE, 32'hFFFF_FFFF);
    send(ACT_WRITE, 32'hA5A5_A5A5);
    send(ACT_WRITE, 32'h5A5A_5A5A);
    send(ACT_COMMIT, 32'h0);
    send(ACT_BEGIN, 32'h0);
    send(ACT_COMMIT, 32'hFFFF_FFFF);
    send(ACT_RESTORE, 32'h1234_5678);
    send(ACT_RESTORE, 32'h0);
    send(ACT_RESTORE, 32'hFFFF_FFFF);
    send(ACT_RESTORE, 32'h5A5A_5A5A);
    send(ACT_RECOVER, 32'h0);
    send(ACT_RECOVER, 32'hFFFF_FFFF);
    send(action_t'(3'd5), 32'hFFFF_FFFF);
    send(action_t'(3'd6), 32'h0);
    send(action_t'(3'd7), 32'hDEAD_BEEF);
    send(ACT_BEGIN, 32'h0);
    send(ACT_WRITE, 32'h1);
    send(ACT_RESTORE, 32'h2);
    send(ACT_WRITE, 32'h2);
    send(ACT_COMMIT, 32'h0);
    drain();

    for (int p = 0; p < 6; p++) begin
      set_log(starts[p], sizes[p]);
      cap = (sizes[p] >= 1) ? sizes[p] - 1 : 0;
      if (cap > MaxEntries) cap = MaxEntries;
      tx_calm = (p == 4);
      run_phase(20, cap);
      drain();
    end

    repeat (200) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
sv/wal_pkg.sv
sv/wal_ram.sv
sv/wal_ctrl.sv
sv/wal_dp.sv
sv/write_ahead_log_controller.sv
tb/sv/wal_journal_checker.sv
tb/sv/testbench.sv
